// ===== rtl/wfu_pkg.sv =====
package wfu_pkg;

   localparam int ByteW  = 8;
   localparam int StatW  = 2;
   localparam int LenW   = 7;
   localparam int HidxW  = 3;
   localparam int KeyN   = 4;
   localparam int KeyIdxW = 2;

   localparam logic [StatW-1:0] ST_DATA   = 2'd0;
   localparam logic [StatW-1:0] ST_EMPTY  = 2'd1;
   localparam logic [StatW-1:0] ST_BADHDR = 2'd2;
   localparam logic [StatW-1:0] ST_TRUNC  = 2'd3;

   localparam logic [ByteW-1:0] FIN_BIT     = 8'h80;
   localparam logic [ByteW-1:0] OPCODE_MASK = 8'h0F;
   localparam logic [ByteW-1:0] OPCODE_TEXT = 8'h01;
   localparam logic [ByteW-1:0] LEN_MASK    = 8'h7F;
   localparam logic [LenW-1:0]  MAX_LEN     = 7'd125;

   localparam logic [HidxW-1:0] HDR_BYTE0   = 3'd0;
   localparam logic [HidxW-1:0] HDR_LENGTH  = 3'd1;
   localparam logic [HidxW-1:0] HDR_KEY0    = 3'd2;
   localparam logic [HidxW-1:0] HDR_KEYLAST = 3'd5;

   typedef struct packed {
      logic [ByteW-1:0] rx_byte;
      logic             frame_start;
      logic             buffer_end;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] payload_byte;
      logic [StatW-1:0] status;
      logic             last_of_frame;
   } rsp_type;

endpackage

// ===== rtl/wfu_if.sv =====
interface wfu_req_if;
   import wfu_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;
   logic             frame_start;
   logic             buffer_end;

   modport source (output valid, output rx_byte, output frame_start, output buffer_end,
                   input ready);
   modport sink   (input valid, input rx_byte, input frame_start, input buffer_end,
                   output ready);
endinterface

interface wfu_rsp_if;
   import wfu_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] payload_byte;
   logic [StatW-1:0] status;
   logic             last_of_frame;

   modport source (output valid, output payload_byte, output status,
                   output last_of_frame, input ready);
   modport sink   (input valid, input payload_byte, input status,
                   input last_of_frame, output ready);
endinterface

// ===== rtl/wfu_ctrl.sv =====
module wfu_ctrl
   import wfu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    res_valid,
   output rsp_type res
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_PAY  = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [HidxW-1:0] hidx_ff, hidx_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [LenW-1:0]  cnt_ff, cnt_in;
   logic [ByteW-1:0] key_ff [KeyN];
   logic [ByteW-1:0] key_in [KeyN];

   logic [1:0]       ph;
   logic [HidxW-1:0] idx;
   logic [HidxW-1:0] kidx;
   logic [LenW-1:0]  len_cur;
   logic [LenW-1:0]  cnt_cur;
   logic [LenW-1:0]  cnt_next;
   logic [LenW-1:0]  n;
   logic [ByteW-1:0] b;
   logic             emit;

   always_comb begin
      b        = req.rx_byte;
      ph       = req.frame_start ? PH_HDR : phase_ff;
      idx      = req.frame_start ? '0 : hidx_ff;
      len_cur  = req.frame_start ? '0 : len_ff;
      cnt_cur  = req.frame_start ? '0 : cnt_ff;
      kidx     = idx - HDR_KEY0;
      n        = LenW'(b & LEN_MASK);
      cnt_next = cnt_cur + 7'd1;

      phase_in = ph;
      hidx_in  = idx;
      len_in   = len_cur;
      cnt_in   = cnt_cur;
      for (int i = 0; i < KeyN; i++) begin
         key_in[i] = key_ff[i];
      end

      emit = 1'b0;
      res  = '0;

      unique case (ph)
         PH_HDR: begin
            if (idx == HDR_BYTE0 &&
                ((b & FIN_BIT) != FIN_BIT || (b & OPCODE_MASK) != OPCODE_TEXT)) begin
               emit       = 1'b1;
               res.status = ST_BADHDR;
            end else if (idx == HDR_LENGTH && n > MAX_LEN) begin
               emit       = 1'b1;
               res.status = ST_BADHDR;
            end else begin
               if (idx == HDR_LENGTH) begin
                  len_in = n;
               end else if (idx != HDR_BYTE0) begin
                  key_in[kidx[KeyIdxW-1:0]] = b;
               end
               hidx_in = idx + 3'd1;
               if (idx >= HDR_KEYLAST) begin
                  if (len_cur == '0) begin
                     emit       = 1'b1;
                     res.status = ST_EMPTY;
                  end else if (req.buffer_end) begin
                     emit       = 1'b1;
                     res.status = ST_TRUNC;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end else if (req.buffer_end) begin
                  emit       = 1'b1;
                  res.status = ST_BADHDR;
               end
            end
         end
         PH_PAY: begin
            emit             = 1'b1;
            res.payload_byte = b ^ key_ff[cnt_cur[KeyIdxW-1:0]];
            cnt_in           = cnt_next;
            if (cnt_next == len_cur) begin
               res.status = ST_DATA;
            end else if (req.buffer_end) begin
               res.status = ST_TRUNC;
            end else begin
               res.status = ST_DATA;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      res.last_of_frame = emit && (ph != PH_PAY || cnt_next == len_cur || req.buffer_end);
      if (res.last_of_frame) begin
         phase_in = PH_IDLE;
      end
      res_valid = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hidx_ff  <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         for (int i = 0; i < KeyN; i++) begin
            key_ff[i] <= '0;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         for (int i = 0; i < KeyN; i++) begin
            key_ff[i] <= key_in[i];
         end
      end
   end

endmodule

// ===== rtl/wfu_rsp_reg.sv =====
module wfu_rsp_reg
   import wfu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type res,
   output logic    can_take,
   wfu_rsp_if.source rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_take = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.payload_byte  = data_ff.payload_byte;
   assign rsp.status        = data_ff.status;
   assign rsp.last_of_frame = data_ff.last_of_frame;

endmodule

// ===== rtl/websocket_frame_unmasker_unit.sv =====
// Where a request gives a result, it is registered and appears on the response channel in the cycle after acceptance.
// Throughput: one request per cycle while results drain; the unmask path is a single XOR between registers.
// A request is taken whenever the result register is empty or being drained in that cycle.
// Reset is synchronous and active high; it returns the parser to idle and clears the mask key.
module websocket_frame_unmasker_unit
   import wfu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   wfu_req_if.sink   req,
   wfu_rsp_if.source rsp
);

   logic    accept;
   logic    can_take;
   logic    res_valid;
   req_type req_data;
   rsp_type res;

   assign req.ready = can_take;
   assign accept    = req.valid && can_take;

   assign req_data.rx_byte     = req.rx_byte;
   assign req_data.frame_start = req.frame_start;
   assign req_data.buffer_end  = req.buffer_end;

   wfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res)
   );

   wfu_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .res      (res),
      .can_take (can_take),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   a_bad_fin: assert property (@(posedge clock) disable iff (reset)
      accept && req.frame_start && !req.rx_byte[7]
      |=> rsp.valid && rsp.status == ST_BADHDR && rsp.last_of_frame)
      else $error("first byte without FIN did not give a header error");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == ST_EMPTY || rsp.status == ST_BADHDR)
      |-> rsp.payload_byte == '0 && rsp.last_of_frame)
      else $error("status-only result carries data or lacks last mark");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("request side stalled while result register could move");
`endif

endmodule
